// ----- src/rvq_pkg.sv -----
`default_nettype none

package rvq_pkg;

  localparam int ATAN_ENTRIES = 24;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [63:0] Q30_PI       = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI  = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI   = 64'd6746518852;
  localparam logic [63:0] Q30_INV_GAIN = 64'd652032874;

  localparam logic [15:0] OUT_ONE = 16'd16384;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec_t;

  // front to back word
  typedef struct packed {
    vec_t        v;
    logic [31:0] sumsq;
    logic        zero;
  } fb_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               ident;
  } res_t;

  // atan(2^-i) in Q.30
  function automatic logic [31:0] atan_val(input int idx);
    case (idx)
      0:       return 32'd843314856;
      1:       return 32'd497837829;
      2:       return 32'd263043836;
      3:       return 32'd133525158;
      4:       return 32'd67021686;
      5:       return 32'd33543515;
      6:       return 32'd16775850;
      7:       return 32'd8388437;
      8:       return 32'd4194282;
      9:       return 32'd2097149;
      10:      return 32'd1048575;
      11:      return 32'd524287;
      12:      return 32'd262143;
      13:      return 32'd131071;
      14:      return 32'd65535;
      15:      return 32'd32767;
      16:      return 32'd16383;
      17:      return 32'd8191;
      18:      return 32'd4095;
      19:      return 32'd2047;
      20:      return 32'd1023;
      21:      return 32'd511;
      22:      return 32'd255;
      23:      return 32'd127;
      default: return 32'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/rvq_ifs.sv -----
`default_nettype none

interface rvq_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;

  modport source(output valid, output angle_x, output angle_y, output angle_z, input ready);
  modport sink(input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

interface rvq_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               is_identity;

  modport source(output valid, output quat_w, output quat_x, output quat_y, output quat_z,
                 output is_identity, input ready);
  modport sink(input valid, input quat_w, input quat_x, input quat_y, input quat_z,
               input is_identity, output ready);
endinterface

`default_nettype wire

// ----- src/rotation_vector_to_quaternion.sv -----
`default_nettype none

// Rotation vector (Q2.13 radians) to unit quaternion (Q1.14, saturated to +-1).
// Accepts one word per clock and delivers one result word per clock when the
// output side keeps ready high; the pipeline has no iterative units. A word
// passes through a two-stage squaring front end, a four-word queue, a 16-stage
// square root, one compare-subtract stage per bit of the two-pi wrap quotient
// (none unless ANGLE_FRAC_BITS is below 13), a fold register, the CORDIC
// pipeline, a scalar register, a multiply stage, a 16-stage divider for the
// vector part and an output register. A stalled output holds the back end;
// the queue lets the front end keep taking words meanwhile. A zero vector gives
// the identity with is_identity set.
module rotation_vector_to_quaternion #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input logic       clk,
  input logic       rst,
  rvq_in_if.sink    din,
  rvq_out_if.source dout
);
  import rvq_pkg::*;

  vec_t in_vec;
  fb_t  push_word, head;
  res_t res;
  logic push, full, not_empty, back_ready;

  assign in_vec.x = din.angle_x;
  assign in_vec.y = din.angle_y;
  assign in_vec.z = din.angle_z;

  rvq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .in_vec    (in_vec),
    .push      (push),
    .full      (full),
    .push_word (push_word)
  );

  rvq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (not_empty && back_ready),
    .not_empty (not_empty),
    .head      (head)
  );

  rvq_back #(
    .TRIG_ITERATIONS (TRIG_ITERATIONS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (not_empty),
    .in_ready  (back_ready),
    .in_word   (head),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_word  (res)
  );

  assign dout.quat_w = res.w;
  assign dout.quat_x = res.x;
  assign dout.quat_y = res.y;
  assign dout.quat_z = res.z;
  assign dout.is_identity = res.ident;

endmodule

`default_nettype wire

// ----- src/rvq_front.sv -----
`default_nettype none

module rvq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rvq_pkg::vec_t in_vec,
  output logic          push,
  input  logic          full,
  output rvq_pkg::fb_t  push_word
);
  import rvq_pkg::*;

  logic               s1_valid;
  vec_t               s1_v;
  logic [31:0]        sq_x, sq_y, sq_z;
  logic               s2_valid;
  fb_t                s2_word;
  logic               en1, en2;
  logic signed [31:0] px, py, pz;
  logic [31:0]        sum;

  assign px = in_vec.x * in_vec.x;
  assign py = in_vec.y * in_vec.y;
  assign pz = in_vec.z * in_vec.z;
  assign sum = sq_x + sq_y + sq_z;

  assign en2 = !s2_valid || !full;
  assign en1 = !s1_valid || en2;
  assign in_ready = en1;
  assign push = s2_valid && !full;
  assign push_word = s2_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
    end
    if (en1) begin
      s1_v <= in_vec;
      sq_x <= unsigned'(px);
      sq_y <= unsigned'(py);
      sq_z <= unsigned'(pz);
    end
    if (en2) begin
      s2_word.v <= s1_v;
      s2_word.sumsq <= sum;
      s2_word.zero <= (sum == 32'd0);
    end
  end

endmodule

`default_nettype wire

// ----- src/rvq_fifo.sv -----
`default_nettype none

module rvq_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  rvq_pkg::fb_t push_word,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output rvq_pkg::fb_t head
);
  import rvq_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  fb_t           mem [0:FIFO_DEPTH-1];
  logic [AW-1:0] wr, rd;
  logic [AW:0]   cnt;

  assign head = mem[rd];
  assign full = (cnt == (AW+1)'(FIFO_DEPTH));
  assign not_empty = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      cnt <= '0;
    end else begin
      if (push) wr <= wr + 1'b1;
      if (pop) rd <= rd + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
    if (push) mem[wr] <= push_word;
  end

endmodule

`default_nettype wire

// ----- src/rvq_back.sv -----
`default_nettype none

module rvq_back #(
  parameter int TRIG_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rvq_pkg::fb_t  in_word,
  output logic          out_valid,
  input  logic          out_ready,
  output rvq_pkg::res_t out_word
);
  import rvq_pkg::*;

  localparam int SHIFT = 29 - ANGLE_FRAC_BITS;
  localparam int HW = 16 + SHIFT;
  localparam int QB = (HW > 32) ? HW - 32 : 0;
  localparam int MW = (HW > 34) ? HW : 34;
  localparam int CN = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
  localparam int CW = 35;
  localparam int SQ_STEPS = 16;
  localparam int DIV_STEPS = 16;
  localparam int LANES = 3;

  localparam logic signed [CW-1:0] PI_S = CW'(Q30_PI);
  localparam logic signed [CW-1:0] HALF_S = CW'(Q30_HALF_PI);
  localparam logic signed [CW-1:0] TWO_S = CW'(Q30_TWO_PI);
  localparam logic signed [CW-1:0] GAIN_S = CW'(Q30_INV_GAIN);

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // square root, one result bit per stage
  logic        sq_ok [0:SQ_STEPS];
  logic [31:0] sq_n  [0:SQ_STEPS];
  logic [31:0] sq_r  [0:SQ_STEPS];
  vec_t        sq_v  [0:SQ_STEPS];
  logic        sq_z  [0:SQ_STEPS];

  assign sq_ok[0] = in_valid;
  assign sq_n[0] = in_word.sumsq;
  assign sq_r[0] = '0;
  assign sq_v[0] = in_word.v;
  assign sq_z[0] = in_word.zero;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * i);
    logic [31:0] trial;
    logic        ge;
    assign trial = sq_r[i] + BIT;
    assign ge = (sq_n[i] >= trial);
    always_ff @(posedge clk) begin
      if (rst) sq_ok[i+1] <= 1'b0;
      else if (en) sq_ok[i+1] <= sq_ok[i];
      if (en) begin
        sq_n[i+1] <= ge ? sq_n[i] - trial : sq_n[i];
        sq_r[i+1] <= ge ? (sq_r[i] >> 1) + BIT : sq_r[i] >> 1;
        sq_v[i+1] <= sq_v[i];
        sq_z[i+1] <= sq_z[i];
      end
    end
  end

  // half angle modulo two pi
  logic          rd_ok [0:QB];
  logic [MW-1:0] rd_h  [0:QB];
  logic [15:0]   rd_t  [0:QB];
  vec_t          rd_v  [0:QB];
  logic          rd_z  [0:QB];

  assign rd_ok[0] = sq_ok[SQ_STEPS];
  assign rd_h[0] = MW'(sq_r[SQ_STEPS][15:0]) << SHIFT;
  assign rd_t[0] = sq_r[SQ_STEPS][15:0];
  assign rd_v[0] = sq_v[SQ_STEPS];
  assign rd_z[0] = sq_z[SQ_STEPS];

  for (genvar k = 0; k < QB; k++) begin : g_rd
    localparam logic [MW-1:0] MODV = MW'(Q30_TWO_PI << (QB - 1 - k));
    logic ge;
    assign ge = (rd_h[k] >= MODV);
    always_ff @(posedge clk) begin
      if (rst) rd_ok[k+1] <= 1'b0;
      else if (en) rd_ok[k+1] <= rd_ok[k];
      if (en) begin
        rd_h[k+1] <= ge ? rd_h[k] - MODV : rd_h[k];
        rd_t[k+1] <= rd_t[k];
        rd_v[k+1] <= rd_v[k];
        rd_z[k+1] <= rd_z[k];
      end
    end
  end

  // fold into [-pi/2, pi/2]
  logic signed [CW-1:0] a0, a1, a_f;
  logic                 neg_f;
  logic                 fd_ok, fd_neg, fd_z;
  logic signed [CW-1:0] fd_a;
  logic [15:0]          fd_t;
  vec_t                 fd_v;

  assign a0 = $signed({1'b0, rd_h[QB][CW-2:0]});
  assign a1 = (a0 > PI_S) ? a0 - TWO_S : a0;

  always_comb begin
    if (a1 > HALF_S) begin
      a_f = PI_S - a1;
      neg_f = 1'b1;
    end else if (a1 < -HALF_S) begin
      a_f = -PI_S - a1;
      neg_f = 1'b1;
    end else begin
      a_f = a1;
      neg_f = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fd_ok <= 1'b0;
    else if (en) fd_ok <= rd_ok[QB];
    if (en) begin
      fd_a <= a_f;
      fd_neg <= neg_f;
      fd_t <= rd_t[QB];
      fd_v <= rd_v[QB];
      fd_z <= rd_z[QB];
    end
  end

  // CORDIC rotation
  logic                 cr_ok  [0:CN];
  logic signed [CW-1:0] cr_x   [0:CN];
  logic signed [CW-1:0] cr_y   [0:CN];
  logic signed [CW-1:0] cr_a   [0:CN];
  logic                 cr_neg [0:CN];
  logic [15:0]          cr_t   [0:CN];
  vec_t                 cr_v   [0:CN];
  logic                 cr_z   [0:CN];

  assign cr_ok[0] = fd_ok;
  assign cr_x[0] = GAIN_S;
  assign cr_y[0] = '0;
  assign cr_a[0] = fd_a;
  assign cr_neg[0] = fd_neg;
  assign cr_t[0] = fd_t;
  assign cr_v[0] = fd_v;
  assign cr_z[0] = fd_z;

  for (genvar i = 0; i < CN; i++) begin : g_cr
    localparam logic signed [CW-1:0] ATAN = CW'(atan_val(i));
    logic signed [CW-1:0] dx, dy;
    assign dx = cr_y[i] >>> i;
    assign dy = cr_x[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) cr_ok[i+1] <= 1'b0;
      else if (en) cr_ok[i+1] <= cr_ok[i];
      if (en) begin
        if (cr_a[i] >= 0) begin
          cr_x[i+1] <= cr_x[i] - dx;
          cr_y[i+1] <= cr_y[i] + dy;
          cr_a[i+1] <= cr_a[i] - ATAN;
        end else begin
          cr_x[i+1] <= cr_x[i] + dx;
          cr_y[i+1] <= cr_y[i] - dy;
          cr_a[i+1] <= cr_a[i] + ATAN;
        end
        cr_neg[i+1] <= cr_neg[i];
        cr_t[i+1] <= cr_t[i];
        cr_v[i+1] <= cr_v[i];
        cr_z[i+1] <= cr_z[i];
      end
    end
  end

  // scalar part and sine magnitude
  logic signed [CW-1:0] cx, cmag, cy, smag;
  logic [CW-1:0]        crnd;
  logic [CW-17:0]       mag;
  logic [15:0]          mag_s;
  logic signed [15:0]   w_val;
  logic                 ps_ok, ps_sneg, ps_z;
  logic signed [15:0]   ps_w;
  logic [31:0]          ps_as;
  logic [15:0]          ps_t;
  vec_t                 ps_v;

  assign cx = cr_neg[CN] ? -cr_x[CN] : cr_x[CN];
  assign cmag = (cx < 0) ? -cx : cx;
  assign crnd = unsigned'(cmag) + CW'(32768);
  assign mag = crnd[CW-1:16];
  assign mag_s = (mag > (CW-16)'(OUT_ONE)) ? OUT_ONE : mag[15:0];
  assign w_val = (cx < 0) ? -$signed(mag_s) : $signed(mag_s);
  assign cy = cr_y[CN];
  assign smag = (cy < 0) ? -cy : cy;

  always_ff @(posedge clk) begin
    if (rst) ps_ok <= 1'b0;
    else if (en) ps_ok <= cr_ok[CN];
    if (en) begin
      ps_w <= w_val;
      ps_as <= smag[31:0];
      ps_sneg <= (cy < 0);
      ps_t <= cr_t[CN];
      ps_v <= cr_v[CN];
      ps_z <= cr_z[CN];
    end
  end

  // numerators
  logic signed [15:0] vl [0:LANES-1];
  logic               mu_ok, mu_sneg, mu_z;
  logic [47:0]        mu_num [0:LANES-1];
  logic [LANES-1:0]   mu_vneg;
  logic signed [15:0] mu_w;
  logic [15:0]        mu_t;

  assign vl[0] = ps_v.x;
  assign vl[1] = ps_v.y;
  assign vl[2] = ps_v.z;

  for (genvar l = 0; l < LANES; l++) begin : g_mu
    logic [15:0] av;
    assign av = (vl[l] < 0) ? unsigned'(-vl[l]) : unsigned'(vl[l]);
    always_ff @(posedge clk) begin
      if (en) begin
        mu_num[l] <= 48'(av) * 48'(ps_as) + (48'(ps_t) << 15);
        mu_vneg[l] <= (vl[l] < 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) mu_ok <= 1'b0;
    else if (en) mu_ok <= ps_ok;
    if (en) begin
      mu_w <= ps_w;
      mu_sneg <= ps_sneg;
      mu_t <= ps_t;
      mu_z <= ps_z;
    end
  end

  // restoring division by theta * 2^16, one quotient bit per stage
  logic               dv_ok   [0:DIV_STEPS];
  logic [47:0]        dv_rem  [0:DIV_STEPS][0:LANES-1];
  logic [15:0]        dv_q    [0:DIV_STEPS][0:LANES-1];
  logic [LANES-1:0]   dv_vneg [0:DIV_STEPS];
  logic signed [15:0] dv_w    [0:DIV_STEPS];
  logic               dv_sneg [0:DIV_STEPS];
  logic [15:0]        dv_t    [0:DIV_STEPS];
  logic               dv_z    [0:DIV_STEPS];

  assign dv_ok[0] = mu_ok;
  assign dv_vneg[0] = mu_vneg;
  assign dv_w[0] = mu_w;
  assign dv_sneg[0] = mu_sneg;
  assign dv_t[0] = mu_t;
  assign dv_z[0] = mu_z;
  for (genvar l = 0; l < LANES; l++) begin : g_dv0
    assign dv_rem[0][l] = mu_num[l];
    assign dv_q[0][l] = '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    localparam int K = DIV_STEPS - 1 - j;
    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic ge;
      assign ge = ((dv_rem[j][l] >> (16 + K)) >= 48'(dv_t[j]));
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem[j+1][l] <= ge ? dv_rem[j][l] - (48'(dv_t[j]) << (16 + K)) : dv_rem[j][l];
          dv_q[j+1][l] <= dv_q[j][l] | (16'(ge) << K);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_ok[j+1] <= 1'b0;
      else if (en) dv_ok[j+1] <= dv_ok[j];
      if (en) begin
        dv_vneg[j+1] <= dv_vneg[j];
        dv_w[j+1] <= dv_w[j];
        dv_sneg[j+1] <= dv_sneg[j];
        dv_t[j+1] <= dv_t[j];
        dv_z[j+1] <= dv_z[j];
      end
    end
  end

  // output register
  logic signed [15:0] qv [0:LANES-1];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    logic [15:0] qs;
    assign qs = (dv_q[DIV_STEPS][l] > OUT_ONE) ? OUT_ONE : dv_q[DIV_STEPS][l];
    assign qv[l] = (dv_vneg[DIV_STEPS][l] != dv_sneg[DIV_STEPS]) ? -$signed(qs) : $signed(qs);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv_ok[DIV_STEPS];
    if (en) begin
      if (dv_z[DIV_STEPS]) begin
        out_word.w <= $signed(OUT_ONE);
        out_word.x <= '0;
        out_word.y <= '0;
        out_word.z <= '0;
        out_word.ident <= 1'b1;
      end else begin
        out_word.w <= dv_w[DIV_STEPS];
        out_word.x <= qv[0];
        out_word.y <= qv[1];
        out_word.z <= qv[2];
        out_word.ident <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/rvq_checker.sv -----
`default_nettype none

module rvq_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] quat_w,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z,
  input logic               is_identity
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(quat_w) && $stable(quat_x) && $stable(quat_y)
      && $stable(quat_z) && $stable(is_identity))
    else $error("output word changed while stalled");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_identity |-> quat_w == 16'sd16384 && quat_x == 16'sd0
      && quat_y == 16'sd0 && quat_z == 16'sd0)
    else $error("identity word malformed");

  a_w_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_w <= 16'sd16384 && quat_w >= -16'sd16384)
    else $error("scalar part out of range");

endmodule

bind rotation_vector_to_quaternion rvq_checker u_rvq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .quat_w      (dout.quat_w),
  .quat_x      (dout.quat_x),
  .quat_y      (dout.quat_y),
  .quat_z      (dout.quat_z),
  .is_identity (dout.is_identity)
);

`default_nettype wire
